@@ rtl/core/greedy_stream_graph_partitioner_defines.svh @@
// Assertion macros for the greedy stream graph partitioner.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef GREEDY_STREAM_GRAPH_PARTITIONER_DEFINES_SVH
`define GREEDY_STREAM_GRAPH_PARTITIONER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GSGP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSGP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/gsgp_pkg.sv @@
// Shared types and constants of the greedy stream graph partitioner.
// No dependencies; used by gsgp_cap_div and the top level.
package gsgp_pkg;

	// Fixed field widths.
	localparam int VID_W     = 16;
	localparam int WGT_W     = 16;
	localparam int PART_W    = 4;
	localparam int SCORE_W   = 32;
	localparam int NV_W      = 17;
	localparam int NP_W      = 5;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 1;
	// A part count can reach the capacity, which is up to 2^17.
	localparam int CNT_W     = 18;
	localparam int DIV_CNT_W = $clog2(NV_W);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTS    = 1'b1;

	// Register reset values.
	localparam logic [NV_W-1:0] NV_RESET = 17'd65536;
	localparam logic [NP_W-1:0] NP_RESET = 5'd16;

	typedef struct packed {
		logic [VID_W-1:0] vertex_id;
		logic [VID_W-1:0] neighbor_id;
		logic [WGT_W-1:0] edge_weight;
		logic             has_neighbor;
		logic             last_neighbor;
	} gsgp_in_t;

	typedef struct packed {
		logic [VID_W-1:0]  placed_vertex;
		logic [PART_W-1:0] chosen_part;
		logic              no_room;
	} gsgp_out_t;

	// Request to and response from the capacity divider.
	typedef struct packed {
		logic            start;
		logic [NV_W-1:0] dividend;
		logic [NP_W-1:0] divisor;
	} gsgp_div_req_t;

	typedef struct packed {
		logic            done;
		logic [NV_W-1:0] quotient;
	} gsgp_div_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_ADD,
		ST_WAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_PLACE
	} gsgp_state_t;

endpackage

@@ rtl/core/greedy_stream_graph_partitioner.sv @@
// Streaming greedy vertex partitioner. Each vertex arrives as a run of requests, one per
// neighbor edge, and the last request of a vertex produces one result with its part. An edge
// request passes through the vertex store read and then the score read and write-back. A
// last request runs the part scan, which reads one score and one count per cycle from the
// part memories, one per part in use; with no part in use the scan is skipped. The next
// request is taken once the result is in the output register, and a result that cannot
// leave the output register holds the placement back. After reset every vertex store
// entry is swept to unassigned with in_ready low. After a write of either register the
// capacity is recomputed by a divider; a placement with parts in use waits until it is
// valid again.
// Depends on gsgp_pkg, gsgp_cap_div and greedy_stream_graph_partitioner_defines.svh.
`include "greedy_stream_graph_partitioner_defines.svh"

module greedy_stream_graph_partitioner
	import gsgp_pkg::*;
#(
	parameter int MAX_VERTICES = 65536,
	parameter int MAX_PARTS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gsgp_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gsgp_out_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int VA_W = $clog2(MAX_VERTICES);
	localparam int PI_W = $clog2(MAX_PARTS);
	// Store entries hold part plus one; the scan counter must also reach the part count.
	localparam int PE_W = $clog2(MAX_PARTS + 1);

	gsgp_state_t state_q, state_d;

	// Configuration and capacity.
	logic [NV_W-1:0]  num_vertices_q;
	logic [NP_W-1:0]  num_parts_q;
	logic             div_req_q;
	logic             cap_valid_q;
	logic [CNT_W-1:0] cap_q;
	logic [31:0]      np_w;
	logic [PE_W-1:0]  np;
	gsgp_div_req_t    div_req;
	gsgp_div_rsp_t    div_rsp;

	// Memories.
	logic [PE_W-1:0]    vps_mem [MAX_VERTICES];
	logic [PE_W-1:0]    vps_rd_q;
	logic [VA_W-1:0]    clr_q;
	logic [SCORE_W-1:0] sc_mem [MAX_PARTS];
	logic [MAX_PARTS-1:0] sc_vld_q;
	logic [SCORE_W-1:0] sc_rd_q;
	logic               sc_rd_vld_q;
	logic [CNT_W-1:0]   cnt_mem [MAX_PARTS];
	logic [MAX_PARTS-1:0] cnt_vld_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic               cnt_rd_vld_q;

	// Edge pipeline.
	logic [VID_W-1:0] vid_s1, vid_s2;
	logic [WGT_W-1:0] wgt_s1, wgt_s2;
	logic             hit_s1, last_s1;
	logic             use_s2, last_s2;
	logic [PI_W-1:0]  part_s2;
	logic [PE_W-1:0]  look_part;
	logic [31:0]      nid_ext, vid_ext;
	logic             nid_ok, vid_ok;
	logic [PI_W-1:0]  sc_raddr;
	logic [SCORE_W:0] sc_sum;
	logic [SCORE_W-1:0] sc_new, sc_old;

	// Scan and selection.
	logic [PE_W-1:0]    k_q;
	logic               cmp_vld_s1;
	logic [PI_W-1:0]    cmp_idx_s1;
	logic [SCORE_W-1:0] score_cur;
	logic [CNT_W-1:0]   cnt_cur, room_cur;
	logic               room_ok, take;
	logic               best_found_q;
	logic [PI_W-1:0]    best_idx_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [CNT_W-1:0]   best_room_q, best_cnt_q;

	// Control from the state machine.
	logic accept, sc_we, scan_init, scan_issue, place_en;

	// Output register.
	logic      out_valid_q;
	gsgp_out_t out_q;

	// Configuration registers; any write schedules a new capacity division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= NV_RESET;
			num_parts_q    <= NP_RESET;
			div_req_q      <= 1'b1;
			cap_valid_q    <= 1'b0;
		end else begin
			div_req_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_VERTICES: num_vertices_q <= cfg_wdata[NV_W-1:0];
					REG_NUM_PARTS:    num_parts_q    <= cfg_wdata[NP_W-1:0];
					default: ;
				endcase
			end
			if (cfg_we || div_req_q) begin
				cap_valid_q <= 1'b0;
			end else if (div_rsp.done) begin
				cap_valid_q <= 1'b1;
			end
		end
	end

	// Capacity is the quotient plus one.
	always_ff @(posedge clk) begin
		if (div_rsp.done) begin
			cap_q <= CNT_W'(div_rsp.quotient) + CNT_W'(1);
		end
	end

	// Parts in use, limited to the parts that exist.
	always_comb begin
		np_w = (32'(num_parts_q) > 32'(MAX_PARTS)) ? 32'(MAX_PARTS) : 32'(num_parts_q);
		np   = np_w[PE_W-1:0];
	end

	assign div_req.start    = div_req_q;
	assign div_req.dividend = num_vertices_q;
	assign div_req.divisor  = np_w[NP_W-1:0];

	gsgp_cap_div u_cap_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		sc_we      = 1'b0;
		scan_init  = 1'b0;
		scan_issue = 1'b0;
		place_en   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == VA_W'(MAX_VERTICES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				sc_we = use_s2;
				if (last_s2) begin
					state_d = ST_WAIT;
				end else begin
					in_ready = 1'b1;
					state_d  = in_valid ? ST_LOOK : ST_IDLE;
				end
			end
			ST_WAIT: begin
				if (np == '0) begin
					scan_init = 1'b1;
					state_d   = ST_PLACE;
				end else if (cap_valid_q) begin
					scan_init = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_issue = 1'b1;
				if (k_q == np - PE_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PLACE;
			end
			ST_PLACE: begin
				if (!out_valid_q || out_ready) begin
					place_en = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// Range checks on the incoming neighbor and on the vertex being placed.
	always_comb begin
		nid_ext   = 32'(in_data.neighbor_id);
		nid_ok    = nid_ext < 32'(MAX_VERTICES);
		vid_ext   = 32'(vid_s2);
		vid_ok    = vid_ext < 32'(MAX_VERTICES);
		look_part = vps_rd_q - PE_W'(1);
	end

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + VA_W'(1);
		end
	end

	// Vertex store: swept at reset, written on placement, read at the neighbor id.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			vps_mem[clr_q] <= '0;
		end else if (place_en && best_found_q && vid_ok) begin
			vps_mem[vid_ext[VA_W-1:0]] <= PE_W'(best_idx_q) + PE_W'(1);
		end
		vps_rd_q <= vps_mem[nid_ext[VA_W-1:0]];
	end

	// First edge stage: hold the request while the store is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else if (accept) begin
			hit_s1  <= in_data.has_neighbor && nid_ok;
			last_s1 <= in_data.last_neighbor;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vid_s1 <= in_data.vertex_id;
			wgt_s1 <= in_data.edge_weight;
		end
	end

	// Edge stage after the store read: the neighbor's part is known and its score is being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else if (state_q == ST_LOOK) begin
			use_s2  <= hit_s1 && (vps_rd_q != '0);
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			vid_s2  <= vid_s1;
			wgt_s2  <= wgt_s1;
			part_s2 <= look_part[PI_W-1:0];
		end
	end

	// Score read address: the scan index during the scan, the neighbor's part otherwise.
	assign sc_raddr = scan_issue ? k_q[PI_W-1:0] : look_part[PI_W-1:0];

	// Saturating score update.
	always_comb begin
		sc_old = sc_rd_vld_q ? sc_rd_q : '0;
		sc_sum = {1'b0, sc_old} + (SCORE_W + 1)'(wgt_s2);
		sc_new = sc_sum[SCORE_W] ? '1 : sc_sum[SCORE_W-1:0];
	end

	// Score memory; an entry without its valid bit reads as zero.
	always_ff @(posedge clk) begin
		if (sc_we) begin
			sc_mem[part_s2] <= sc_new;
		end
		sc_rd_q <= sc_mem[sc_raddr];
	end

	// Count memory; written only on a successful placement.
	always_ff @(posedge clk) begin
		if (place_en && best_found_q) begin
			cnt_mem[best_idx_q] <= best_cnt_q + CNT_W'(1);
		end
		cnt_rd_q <= cnt_mem[k_q[PI_W-1:0]];
	end

	// Valid bits of both part memories and their registered read copies.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_vld_q     <= '0;
			cnt_vld_q    <= '0;
			sc_rd_vld_q  <= 1'b0;
			cnt_rd_vld_q <= 1'b0;
		end else begin
			sc_rd_vld_q  <= sc_vld_q[sc_raddr];
			cnt_rd_vld_q <= cnt_vld_q[k_q[PI_W-1:0]];
			if (place_en) begin
				sc_vld_q <= '0;
			end else if (sc_we) begin
				sc_vld_q[part_s2] <= 1'b1;
			end
			if (place_en && best_found_q) begin
				cnt_vld_q[best_idx_q] <= 1'b1;
			end
		end
	end

	// Scan index and compare-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= scan_issue;
			if (scan_init) begin
				k_q <= '0;
			end else if (scan_issue) begin
				k_q <= k_q + PE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= k_q[PI_W-1:0];
	end

	// Candidate test: room left, higher score, or equal score with less room.
	always_comb begin
		score_cur = sc_rd_vld_q ? sc_rd_q : '0;
		cnt_cur   = cnt_rd_vld_q ? cnt_rd_q : '0;
		room_ok   = cnt_cur < cap_q;
		room_cur  = cap_q - cnt_cur;
		take      = room_ok && (!best_found_q || (score_cur > best_score_q) ||
			((score_cur == best_score_q) && (room_cur < best_room_q)));
	end

	// Best candidate so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (scan_init) begin
			best_found_q <= 1'b0;
		end else if (cmp_vld_s1 && take) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && take) begin
			best_idx_q   <= cmp_idx_s1;
			best_score_q <= score_cur;
			best_room_q  <= room_cur;
			best_cnt_q   <= cnt_cur;
		end
	end

	// Output register: it frees the input side while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (place_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			out_q.placed_vertex <= vid_s2;
			out_q.chosen_part   <= best_found_q ? PART_W'(best_idx_q) : '0;
			out_q.no_room       <= !best_found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks on sequencing.
	`GSGP_ASSERT_NEXT(a_accept_to_look, accept, state_q == ST_LOOK, "accepted request did not enter store lookup")
	`GSGP_ASSERT_NOW(a_clear_blocks, state_q == ST_CLEAR, !in_ready && !out_valid_q, "activity during store clearing")
	`GSGP_ASSERT_NEXT(a_place_resets, place_en, (sc_vld_q == '0) && out_valid_q, "placement did not clear scores or post a result")
	`GSGP_ASSERT_NOW(a_cmp_in_scan, cmp_vld_s1, (state_q == ST_SCAN) || (state_q == ST_DRAIN), "compare stage active outside the scan")

endmodule

@@ rtl/core/gsgp_cap_div.sv @@
// Restoring divider, one quotient bit per cycle, for the per-part capacity.
// Depends on gsgp_pkg.
module gsgp_cap_div
	import gsgp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  gsgp_div_req_t req,
	output gsgp_div_rsp_t rsp
);

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(NV_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NV_W-1:0]      dq_q;
	logic [NP_W-1:0]      rem_q;
	logic [NP_W-1:0]      den_q;
	logic [NP_W:0]        trial;
	logic [NP_W:0]        diff;
	logic                 ge;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial = {rem_q, dq_q[NV_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Control: a start always restarts, even in the middle of a division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out on the left as quotient bits enter on the right.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NP_W-1:0] : trial[NP_W-1:0];
			dq_q  <= {dq_q[NV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule
